FILE: rtl/igt_pkg.sv
package igt_pkg;

  // Field widths fixed by the register map and the item format.
  localparam int unsigned DIM_W      = 9;   // image and crop dimensions
  localparam int unsigned ARG_W      = 8;   // arg_a, arg_b
  localparam int unsigned PIX_W      = 8;   // grey value
  localparam int unsigned COORD_W    = 16;  // out_row, out_col ports
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  // Largest output extent is a tiled image: 511 rows times 255 copies.
  localparam int unsigned CNT_W      = 17;
  // Largest pixel count of a loaded image: 511 by 511.
  localparam int unsigned TOT_W      = 2 * DIM_W;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_ADDR_W = 5;

  localparam int unsigned MAX_COLS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_CW   = 3'd0,
    MODE_CCW  = 3'd1,
    MODE_PAD  = 3'd2,
    MODE_TILE = 3'd3,
    MODE_CROP = 3'd4
  } mode_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_LOADED  = 2'd0,
    STS_PIXEL   = 2'd1,
    STS_BAD_CFG = 2'd2,
    STS_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_OP_MODE    = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_IMAGE_ROWS = 3'd2,
    REG_ARG_A      = 3'd3,
    REG_ARG_B      = 3'd4,
    REG_CROP_ROWS  = 3'd5,
    REG_CROP_COLS  = 3'd6,
    REG_FILL_VALUE = 3'd7
  } reg_e;

  // Outcome of the bounds check of a fetch.
  typedef enum logic [1:0] {
    CHK_BAD,    // configuration rejected
    CHK_NONE,   // image incomplete or sequence finished
    CHK_END,    // position beyond the output image
    CHK_PIX     // a pixel is produced
  } chk_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIM,
    ST_CHECK,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] op_mode;
    logic [DIM_W-1:0]  image_cols;
    logic [DIM_W-1:0]  image_rows;
    logic [ARG_W-1:0]  arg_a;
    logic [ARG_W-1:0]  arg_b;
    logic [DIM_W-1:0]  crop_rows;
    logic [DIM_W-1:0]  crop_cols;
    logic [PIX_W-1:0]  fill_value;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    op_mode:    MODE_CW,
    image_cols: 9'd256,
    image_rows: 9'd256,
    arg_a:      8'd0,
    arg_b:      8'd0,
    crop_rows:  9'd1,
    crop_cols:  9'd1,
    fill_value: 8'd0
  };

  typedef struct packed {
    logic load;        // store the input pixel and report it loaded
    logic dim;         // register output extents
    logic check;       // bounds check, early status or source coordinates
    logic div_start;   // start the tile remainder units
    logic addr;        // form the store address
    logic pix_res;     // deliver the pixel and advance the position
  } ctrl_cmd_t;

  typedef struct packed {
    chk_e chk;
    logic tile;
    logic div_busy;
  } dp_status_t;

endpackage

FILE: rtl/igt_ram.sv
module igt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/igt_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
module igt_mod #(
  parameter int unsigned DVD_W = 17,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      // The partial remainder stays below the divisor, so either branch fits.
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/igt_datapath.sv
module igt_datapath import igt_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          sts_o,
  input  logic [PIX_W-1:0]    pixel_in_i,
  output logic [STATUS_W-1:0] res_status_o,
  output logic [PIX_W-1:0]    res_pixel_o,
  output logic [COORD_W-1:0]  res_row_o,
  output logic [COORD_W-1:0]  res_col_o,
  output logic                res_last_o
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Sequence state.
  logic [TOT_W-1:0] load_count_q, load_count_d;
  logic [CNT_W-1:0] emit_row_q, emit_row_d;
  logic [CNT_W-1:0] emit_col_q, emit_col_d;
  logic             emit_done_q, emit_done_d;

  // Per-fetch working registers.
  logic [DIM_W-1:0] nr_q, nc_q;
  logic [CNT_W-1:0] orows_q, ocols_q;
  logic [TOT_W-1:0] total_q;
  logic             bad_q, tile_q;
  logic [DIM_W-1:0] sr_q, sc_q;
  logic             fill_q;
  logic [AW-1:0]    addr_q;

  // Result register.
  logic [STATUS_W-1:0] res_status_q;
  logic [PIX_W-1:0]    res_pixel_q;
  logic [COORD_W-1:0]  res_row_q, res_col_q;
  logic                res_last_q;

  logic [DIM_W-1:0] nr_c, nc_c;
  logic [TOT_W-1:0] total_c;
  logic [TOT_W-1:0] load_slot;
  logic [CNT_W-1:0] orows_c, ocols_c;
  logic             bad_c;
  chk_e             chk_c;
  logic [DIM_W-1:0] sr_c, sc_c;
  logic             fill_c;
  logic [DIM_W-1:0] sr_use, sc_use;
  logic [TOT_W-1:0] addr_c;
  logic [PIX_W-1:0] ram_rdata;
  logic             last_c;
  logic             row_busy, col_busy;
  logic [DIM_W-1:0] row_rem, col_rem;
  logic [DIM_W:0]   crop_row_end, crop_col_end;

  // Image size saturated to the supported range.
  assign nc_c = (cfg_i.image_cols == '0) ? DIM_W'(1) :
                ((int'(cfg_i.image_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : cfg_i.image_cols);
  assign nr_c = (cfg_i.image_rows == '0) ? DIM_W'(1) :
                ((int'(cfg_i.image_rows) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : cfg_i.image_rows);
  assign total_c = TOT_W'(nr_c) * TOT_W'(nc_c);

  // A load into a complete image starts a new frame.
  assign load_slot = (load_count_q >= total_c) ? '0 : load_count_q;

  assign crop_row_end = (DIM_W+1)'(cfg_i.arg_a) + (DIM_W+1)'(cfg_i.crop_rows);
  assign crop_col_end = (DIM_W+1)'(cfg_i.arg_b) + (DIM_W+1)'(cfg_i.crop_cols);

  // Output extents of the configured transform.
  always_comb begin
    orows_c = '0;
    ocols_c = '0;
    bad_c   = 1'b0;
    case (cfg_i.op_mode)
      MODE_CW, MODE_CCW: begin
        orows_c = CNT_W'(nc_c);
        ocols_c = CNT_W'(nr_c);
      end
      MODE_PAD: begin
        orows_c = CNT_W'(nr_c) + (CNT_W'(cfg_i.arg_a) << 1);
        ocols_c = CNT_W'(nc_c) + (CNT_W'(cfg_i.arg_a) << 1);
      end
      MODE_TILE: begin
        bad_c   = (cfg_i.arg_a == '0) || (cfg_i.arg_b == '0);
        orows_c = CNT_W'(nr_c) * CNT_W'(cfg_i.arg_a);
        ocols_c = CNT_W'(nc_c) * CNT_W'(cfg_i.arg_b);
      end
      MODE_CROP: begin
        bad_c   = (cfg_i.crop_rows == '0) || (cfg_i.crop_cols == '0) ||
                  (crop_row_end > (DIM_W+1)'(nr_c)) || (crop_col_end > (DIM_W+1)'(nc_c));
        orows_c = CNT_W'(cfg_i.crop_rows);
        ocols_c = CNT_W'(cfg_i.crop_cols);
      end
      default: begin
        bad_c = 1'b1;
      end
    endcase
  end

  // Bounds check against the registered extents.
  always_comb begin
    if (bad_q) begin
      chk_c = CHK_BAD;
    end else if ((load_count_q < total_q) || emit_done_q) begin
      chk_c = CHK_NONE;
    end else if ((emit_row_q >= orows_q) || (emit_col_q >= ocols_q)) begin
      chk_c = CHK_END;
    end else begin
      chk_c = CHK_PIX;
    end
  end

  // Source coordinates; truncation is exact whenever the position is in range.
  always_comb begin
    sr_c   = '0;
    sc_c   = '0;
    fill_c = 1'b0;
    case (cfg_i.op_mode)
      MODE_CW: begin
        sr_c = nr_q - 1'b1 - emit_col_q[DIM_W-1:0];
        sc_c = emit_row_q[DIM_W-1:0];
      end
      MODE_CCW: begin
        sr_c = emit_col_q[DIM_W-1:0];
        sc_c = nc_q - 1'b1 - emit_row_q[DIM_W-1:0];
      end
      MODE_PAD: begin
        fill_c = (emit_row_q < CNT_W'(cfg_i.arg_a)) ||
                 (emit_row_q >= CNT_W'(nr_q) + CNT_W'(cfg_i.arg_a)) ||
                 (emit_col_q < CNT_W'(cfg_i.arg_a)) ||
                 (emit_col_q >= CNT_W'(nc_q) + CNT_W'(cfg_i.arg_a));
        sr_c = DIM_W'(emit_row_q - CNT_W'(cfg_i.arg_a));
        sc_c = DIM_W'(emit_col_q - CNT_W'(cfg_i.arg_a));
      end
      MODE_CROP: begin
        sr_c = DIM_W'(CNT_W'(cfg_i.arg_a) + emit_row_q);
        sc_c = DIM_W'(CNT_W'(cfg_i.arg_b) + emit_col_q);
      end
      default: begin
        sr_c = '0;
        sc_c = '0;
      end
    endcase
  end

  // Tiling takes the source position from the remainder units.
  assign sr_use = tile_q ? row_rem : sr_q;
  assign sc_use = tile_q ? col_rem : sc_q;
  assign addr_c = TOT_W'(sr_use) * TOT_W'(nc_q) + TOT_W'(sc_use);

  assign last_c = (emit_row_q == orows_q - 1'b1) && (emit_col_q == ocols_q - 1'b1);

  always_comb begin
    load_count_d = load_count_q;
    emit_row_d   = emit_row_q;
    emit_col_d   = emit_col_q;
    emit_done_d  = emit_done_q;
    if (cmd_i.load) begin
      load_count_d = load_slot + 1'b1;
      emit_row_d   = '0;
      emit_col_d   = '0;
      emit_done_d  = 1'b0;
    end else if (cmd_i.check && (chk_c == CHK_END)) begin
      emit_done_d = 1'b1;
    end else if (cmd_i.pix_res) begin
      if (last_c) begin
        emit_done_d = 1'b1;
      end else if (emit_col_q + 1'b1 >= ocols_q) begin
        emit_col_d = '0;
        emit_row_d = emit_row_q + 1'b1;
      end else begin
        emit_col_d = emit_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      emit_row_q   <= '0;
      emit_col_q   <= '0;
      emit_done_q  <= 1'b0;
    end else begin
      load_count_q <= load_count_d;
      emit_row_q   <= emit_row_d;
      emit_col_q   <= emit_col_d;
      emit_done_q  <= emit_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dim) begin
      nr_q    <= nr_c;
      nc_q    <= nc_c;
      orows_q <= orows_c;
      ocols_q <= ocols_c;
      total_q <= total_c;
      bad_q   <= bad_c;
      tile_q  <= (cfg_i.op_mode == MODE_TILE);
    end
    if (cmd_i.check) begin
      sr_q   <= sr_c;
      sc_q   <= sc_c;
      fill_q <= fill_c;
    end
    if (cmd_i.addr) begin
      addr_q <= AW'(addr_c);
    end
    if (cmd_i.load) begin
      res_status_q <= STS_LOADED;
      res_pixel_q  <= '0;
      res_row_q    <= '0;
      res_col_q    <= '0;
      res_last_q   <= 1'b0;
    end else if (cmd_i.check && (chk_c != CHK_PIX)) begin
      res_status_q <= (chk_c == CHK_BAD) ? STS_BAD_CFG : STS_EMPTY;
      res_pixel_q  <= '0;
      res_row_q    <= '0;
      res_col_q    <= '0;
      res_last_q   <= 1'b0;
    end else if (cmd_i.pix_res) begin
      res_status_q <= STS_PIXEL;
      res_pixel_q  <= fill_q ? cfg_i.fill_value : ram_rdata;
      res_row_q    <= emit_row_q[COORD_W-1:0];
      res_col_q    <= emit_col_q[COORD_W-1:0];
      res_last_q   <= last_c;
    end
  end

  igt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (AW'(load_slot)),
    .wdata_i (pixel_in_i),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  igt_mod #(
    .DVD_W (CNT_W),
    .DVS_W (DIM_W)
  ) u_row_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (emit_row_q),
    .divisor_i  (nr_q),
    .busy_o     (row_busy),
    .rem_o      (row_rem)
  );

  igt_mod #(
    .DVD_W (CNT_W),
    .DVS_W (DIM_W)
  ) u_col_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (emit_col_q),
    .divisor_i  (nc_q),
    .busy_o     (col_busy),
    .rem_o      (col_rem)
  );

  assign sts_o.chk      = chk_c;
  assign sts_o.tile     = tile_q;
  assign sts_o.div_busy = row_busy | col_busy;

  assign res_status_o = res_status_q;
  assign res_pixel_o  = res_pixel_q;
  assign res_row_o    = res_row_q;
  assign res_col_o    = res_col_q;
  assign res_last_o   = res_last_q;

endmodule

FILE: rtl/igt_ctrl.sv
module igt_ctrl import igt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      accept;
  logic      res_set;
  ctrl_cmd_t cmd;

  // One item at a time; a new one waits until the result register is empty.
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_FETCH)) begin
          state_d = ST_DIM;
        end
      end
      ST_DIM: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.chk != CHK_PIX) begin
          state_d = ST_IDLE;
        end else if (sts_i.tile) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_ADDR;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_q)
      ST_IDLE: begin
        cmd.load = accept && (func_i == FUNC_LOAD);
      end
      ST_DIM: begin
        cmd.dim = 1'b1;
      end
      ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = (sts_i.chk == CHK_PIX) && sts_i.tile;
      end
      ST_ADDR: begin
        cmd.addr = 1'b1;
      end
      ST_RESP: begin
        cmd.pix_res = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign res_set = cmd.load || (cmd.check && (sts_i.chk != CHK_PIX)) || cmd.pix_res;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_set) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/image_geometry_transform.sv
// Grey image rotate, pad, tile and crop engine. Pixels are loaded in raster order into an
// on-chip frame store of MAX_COLS * MAX_ROWS bytes (func 0); fetches (func 1) return the
// transformed image in raster order with its row, column and a last flag, or a status of
// bad configuration or nothing available. The block works on one item at a time. A load
// delivers its result in the cycle after it is accepted. A fetch that ends in a status
// without a pixel stops after the extent multiply and bounds check; a pixel fetch goes on
// through address multiply and a registered frame store read, and a pixel fetch while tiling
// also waits for the row and column remainders from a restoring remainder unit that resolves
// one bit of the 17-bit position per cycle. The next item is accepted in the cycle after the
// result is taken. Configuration registers sit on the APB port and must only change while no
// item is in flight.
module image_geometry_transform import igt_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  // Result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic                  last_o
);

  cfg_t       cfg_q, cfg_d;
  reg_e       reg_sel;
  logic       cfg_write;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign pready    = 1'b1;
  assign reg_sel   = reg_e'(paddr[REG_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_sel)
        REG_OP_MODE:    cfg_d.op_mode    = pwdata[MODE_W-1:0];
        REG_IMAGE_COLS: cfg_d.image_cols = pwdata[DIM_W-1:0];
        REG_IMAGE_ROWS: cfg_d.image_rows = pwdata[DIM_W-1:0];
        REG_ARG_A:      cfg_d.arg_a      = pwdata[ARG_W-1:0];
        REG_ARG_B:      cfg_d.arg_b      = pwdata[ARG_W-1:0];
        REG_CROP_ROWS:  cfg_d.crop_rows  = pwdata[DIM_W-1:0];
        REG_CROP_COLS:  cfg_d.crop_cols  = pwdata[DIM_W-1:0];
        REG_FILL_VALUE: cfg_d.fill_value = pwdata[PIX_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OP_MODE:    prdata = APB_DATA_W'(cfg_q.op_mode);
      REG_IMAGE_COLS: prdata = APB_DATA_W'(cfg_q.image_cols);
      REG_IMAGE_ROWS: prdata = APB_DATA_W'(cfg_q.image_rows);
      REG_ARG_A:      prdata = APB_DATA_W'(cfg_q.arg_a);
      REG_ARG_B:      prdata = APB_DATA_W'(cfg_q.arg_b);
      REG_CROP_ROWS:  prdata = APB_DATA_W'(cfg_q.crop_rows);
      REG_CROP_COLS:  prdata = APB_DATA_W'(cfg_q.crop_cols);
      REG_FILL_VALUE: prdata = APB_DATA_W'(cfg_q.fill_value);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  igt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  igt_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_in_i   (pixel_in_i),
    .res_status_o (status_o),
    .res_pixel_o  (pixel_out_o),
    .res_row_o    (out_row_o),
    .res_col_o    (out_col_o),
    .res_last_o   (last_o)
  );

  // A load is answered in the very next cycle.
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FUNC_LOAD)
      |=> out_valid_o && (status_o == STS_LOADED))
    else $error("load item not answered with a loaded status");

  // Results without a pixel carry zero payload.
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_PIXEL)
      |-> (pixel_out_o == '0) && (out_row_o == '0) && (out_col_o == '0) && !last_o)
    else $error("non-pixel result with nonzero payload");

  // No item is taken while a result is pending.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o && !sts.div_busy)
    else $error("input ready while an item is still in flight");

endmodule
